FILE: src/jacobi_stencil_3d_engine_unit_assert.svh
// Assertion macros shared by the stencil engine RTL.
`ifndef JACOBI_STENCIL_3D_ENGINE_UNIT_ASSERT_SVH
`define JACOBI_STENCIL_3D_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JSE_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSE_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/jse_pkg.sv
// Shared types, constants and fixed-point helpers of the stencil engine.
package jse_pkg;

   localparam int GRID_SIDE  = 16;
   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int COORD_W    = $clog2(GRID_SIDE);
   localparam int SIDE_W     = $clog2(GRID_SIDE + 1);
   localparam int SS_W       = $clog2(GRID_SIDE * GRID_SIDE + 1);
   localparam int DATA_W     = 32;
   localparam int STEP_W     = 16;
   localparam int CFG_SIDE_W = 5;
   localparam int REG_IDX_W  = 3;
   localparam int PHASE_W    = 3;

   // Request commands
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_RUN  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_RUN_DONE = 2'd0;
   localparam logic [1:0] KIND_READ     = 2'd1;
   localparam logic [1:0] KIND_RANGE    = 2'd2;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_CENTER = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_WA     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WB     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WC     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STEPS  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SIDE   = 3'd5;

   // Read phases of one cell: center, then z+, z-, y+, y-, x+, x-
   localparam logic [PHASE_W-1:0] PH_CENTER = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ZP     = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ZM     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_YP     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_YM     = 3'd4;
   localparam logic [PHASE_W-1:0] PH_XP     = 3'd5;
   localparam logic [PHASE_W-1:0] PH_XM     = 3'd6;

   typedef struct packed {
      logic [1:0]               command;
      logic [11:0]              cell_index;
      logic signed [DATA_W-1:0] cell_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               result_kind;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

   // Memory traffic and status from the sweep sequencer
   typedef struct packed {
      logic [ADDR_W-1:0]        rd_addr;
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     flip;
      logic                     done;
   } sweep_ctl_type;

   typedef enum logic [1:0] {TOP_IDLE, TOP_RUN, TOP_DONE} top_state_type;
   typedef enum logic [1:0] {SW_IDLE, SW_RUN, SW_DRAIN} sweep_state_type;

   // Saturating signed 32-bit add
   function automatic logic signed [DATA_W-1:0] sat_add(logic signed [DATA_W-1:0] a,
                                                      logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sat_add = s[DATA_W-1:0];
      end
   endfunction

   // Floor shift of a Q32.32 product back to Q16.16, saturated
   function automatic logic signed [DATA_W-1:0] sat_shift(logic signed [63:0] p);
      logic signed [47:0] q;
      q = p[63:16];
      if (q[47:31] == {17{q[47]}}) begin
         sat_shift = q[31:0];
      end else begin
         sat_shift = q[47] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

FILE: src/jse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: src/jse_sweep.sv
// Sweep sequencer: walks the grid, reads seven cells per active cell, copies the rest, multiplies and accumulates.
module jse_sweep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [jse_pkg::SIDE_W-1:0]       side,
   input  logic signed [jse_pkg::DATA_W-1:0] center_weight,
   input  logic signed [jse_pkg::DATA_W-1:0] nbr_weight,
   input  logic [jse_pkg::STEP_W-1:0]       steps,
   input  logic signed [jse_pkg::DATA_W-1:0] rd_data,
   output jse_pkg::sweep_ctl_type           ctl
);

   localparam int AW = jse_pkg::ADDR_W;
   localparam int DW = jse_pkg::DATA_W;

   jse_pkg::sweep_state_type state_ff, state_in;

   logic [jse_pkg::COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [jse_pkg::CNT_W-1:0]   i_ff, i_in;
   logic [jse_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [jse_pkg::STEP_W-1:0]  sweeps_ff, sweeps_in;

   logic v1_ff, mask1_ff, first1_ff, last1_ff, copy1_ff;
   logic [AW-1:0] idx1_ff;
   logic v2_ff, first2_ff, last2_ff, copy2_ff;
   logic [AW-1:0] idx2_ff;
   logic signed [63:0] prod2_ff, prod2_in;
   logic signed [DW-1:0] raw2_ff, acc_ff, acc_in;
   logic wr_en_ff;
   logic [AW-1:0] wr_addr_ff;
   logic signed [DW-1:0] wr_data_ff;

   logic [jse_pkg::SS_W-1:0]  ss;
   logic [jse_pkg::CNT_W-1:0] cells;
   logic in_compute, issue, at_end, drained, flip, last_sweep;
   logic [AW-1:0] idx, rd_addr;
   logic mask, first, last;
   logic z_hi, z_lo, y_hi, y_lo, x_hi, x_lo;
   logic signed [DW-1:0] wsel, term, sum;

   // Grid geometry
   assign ss    = jse_pkg::SS_W'(side) * jse_pkg::SS_W'(side);
   assign cells = jse_pkg::CNT_W'(ss) * jse_pkg::CNT_W'(side);
   assign idx   = i_ff[AW-1:0];
   assign in_compute = i_ff < cells;

   assign z_hi = (jse_pkg::SIDE_W'(z_ff) + jse_pkg::SIDE_W'(1)) < side;
   assign y_hi = (jse_pkg::SIDE_W'(y_ff) + jse_pkg::SIDE_W'(1)) < side;
   assign x_hi = (jse_pkg::SIDE_W'(x_ff) + jse_pkg::SIDE_W'(1)) < side;
   assign z_lo = z_ff != '0;
   assign y_lo = y_ff != '0;
   assign x_lo = x_ff != '0;

   // Pick neighbor address and edge mask for this phase
   always_comb begin
      rd_addr = idx;
      mask    = 1'b1;
      if (in_compute) begin
         case (phase_ff)
            jse_pkg::PH_ZP: begin rd_addr = idx + AW'(1);       mask = z_hi; end
            jse_pkg::PH_ZM: begin rd_addr = idx - AW'(1);       mask = z_lo; end
            jse_pkg::PH_YP: begin rd_addr = idx + AW'(side);    mask = y_hi; end
            jse_pkg::PH_YM: begin rd_addr = idx - AW'(side);    mask = y_lo; end
            jse_pkg::PH_XP: begin rd_addr = idx + AW'(ss);      mask = x_hi; end
            jse_pkg::PH_XM: begin rd_addr = idx - AW'(ss);      mask = x_lo; end
            default:        begin rd_addr = idx;                mask = 1'b1; end
         endcase
      end
   end

   assign first = !in_compute || (phase_ff == jse_pkg::PH_CENTER);
   assign last  = !in_compute || (phase_ff == jse_pkg::PH_XM);

   // Sequencer status
   assign issue      = state_ff == jse_pkg::SW_RUN;
   assign at_end     = issue && (i_ff == jse_pkg::CNT_W'(jse_pkg::CELL_COUNT - 1)) && last;
   assign drained    = !v1_ff && !v2_ff && !wr_en_ff;
   assign last_sweep = (sweeps_ff + jse_pkg::STEP_W'(1)) == steps;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jse_pkg::SW_IDLE:  if (start) state_in = jse_pkg::SW_RUN;
         jse_pkg::SW_RUN:   if (at_end) state_in = jse_pkg::SW_DRAIN;
         jse_pkg::SW_DRAIN: begin
            if (drained) state_in = last_sweep ? jse_pkg::SW_IDLE : jse_pkg::SW_RUN;
         end
         default:           state_in = jse_pkg::SW_IDLE;
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      flip = 1'b0;
      unique case (state_ff)
         jse_pkg::SW_DRAIN: flip = drained;
         default:           flip = 1'b0;
      endcase
   end

   // Advance cell walk and sweep count
   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      i_in      = i_ff;
      phase_in  = phase_ff;
      sweeps_in = sweeps_ff;
      if (state_ff == jse_pkg::SW_IDLE || flip) begin
         x_in     = '0;
         y_in     = '0;
         z_in     = '0;
         i_in     = '0;
         phase_in = jse_pkg::PH_CENTER;
         if (state_ff == jse_pkg::SW_IDLE && start) sweeps_in = '0;
         if (flip) sweeps_in = sweeps_ff + jse_pkg::STEP_W'(1);
      end else if (issue) begin
         if (in_compute && !last) begin
            phase_in = phase_ff + jse_pkg::PHASE_W'(1);
         end else begin
            phase_in = jse_pkg::PH_CENTER;
            i_in     = i_ff + jse_pkg::CNT_W'(1);
            if (in_compute) begin
               if (z_hi) begin
                  z_in = z_ff + jse_pkg::COORD_W'(1);
               end else begin
                  z_in = '0;
                  if (y_hi) begin
                     y_in = y_ff + jse_pkg::COORD_W'(1);
                  end else begin
                     y_in = '0;
                     x_in = x_ff + jse_pkg::COORD_W'(1);
                  end
               end
            end
         end
      end
   end

   // Multiply stage: center weight on the first read, neighbor weight after
   assign wsel     = first1_ff ? center_weight : nbr_weight;
   assign prod2_in = mask1_ff ? (64'(wsel) * 64'(rd_data)) : '0;

   // Accumulate stage with saturation
   assign term   = jse_pkg::sat_shift(prod2_ff);
   assign sum    = first2_ff ? term : jse_pkg::sat_add(acc_ff, term);
   assign acc_in = v2_ff ? sum : acc_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= jse_pkg::SW_IDLE;
         x_ff      <= '0;
         y_ff      <= '0;
         z_ff      <= '0;
         i_ff      <= '0;
         phase_ff  <= jse_pkg::PH_CENTER;
         sweeps_ff <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         wr_en_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         z_ff      <= z_in;
         i_ff      <= i_in;
         phase_ff  <= phase_in;
         sweeps_ff <= sweeps_in;
         v1_ff     <= issue;
         v2_ff     <= v1_ff;
         wr_en_ff  <= v2_ff && last2_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      mask1_ff   <= mask;
      first1_ff  <= first;
      last1_ff   <= last;
      copy1_ff   <= !in_compute;
      idx1_ff    <= idx;
      first2_ff  <= first1_ff;
      last2_ff   <= last1_ff;
      copy2_ff   <= copy1_ff;
      idx2_ff    <= idx1_ff;
      prod2_ff   <= prod2_in;
      raw2_ff    <= rd_data;
      acc_ff     <= acc_in;
      wr_addr_ff <= idx2_ff;
      wr_data_ff <= copy2_ff ? raw2_ff : sum;
   end

   assign ctl.rd_addr = rd_addr;
   assign ctl.wr_en   = wr_en_ff;
   assign ctl.wr_addr = wr_addr_ff;
   assign ctl.wr_data = wr_data_ff;
   assign ctl.flip    = flip;
   assign ctl.done    = flip && last_sweep;

endmodule

FILE: src/jacobi_stencil_3d_engine_unit.sv
// Top level of the 3-D seven-point Jacobi stencil engine.
//
// Requests arrive on req_valid/req_ready with a command, a cell index and a
// value; results leave on rsp_valid/rsp_ready. Registers are written through
// csr_write_en/csr_index/csr_data; the user must write them only while the
// engine is idle, as the block itself does not enforce this. A load gives no
// result; a read or an out-of-range load/read gives one result, the read's
// data passing through the read-pending register and the result register.
// Loads stream one request a cycle while no result is stalled; a read holds
// the request side while the grid memory returns its data.
// A run holds the request side for its whole length. Each sweep issues one
// memory read a cycle: seven reads for each of S^3 active cells plus one
// copy read for each of the 4096 - S^3 remaining cells, then the
// multiply/accumulate pipeline drains. A run ends with one result.
// Two grid banks swap roles after every sweep.
// Reset restores the register defaults and idles the engine; grid contents
// are undefined until loaded. A stalled result holds the request side.
module jacobi_stencil_3d_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  jse_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output jse_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_write_en,
   input  logic [jse_pkg::REG_IDX_W-1:0]     csr_index,
   input  logic [jse_pkg::DATA_W-1:0]        csr_data
);

   `include "jacobi_stencil_3d_engine_unit_assert.svh"

   localparam int AW = jse_pkg::ADDR_W;
   localparam int DW = jse_pkg::DATA_W;

   jse_pkg::top_state_type state_ff, state_in;

   logic signed [DW-1:0] center_ff, wa_ff, wb_ff, wc_ff;
   logic [jse_pkg::STEP_W-1:0]     steps_ff;
   logic [jse_pkg::CFG_SIDE_W-1:0] side_ff;

   logic cur_ff, rd_pend_ff, rsp_valid_ff, rsp_valid_in;
   jse_pkg::rsp_type rsp_ff, rsp_in;

   logic [jse_pkg::SIDE_W-1:0]  side;
   logic [jse_pkg::SS_W-1:0]    ss;
   logic [jse_pkg::CNT_W-1:0]   cells;
   logic signed [DW-1:0]        nbr_weight;
   logic accept, in_range, load_we, read_req, range_err, run_req, done_emit, sw_start;
   logic [AW-1:0] req_addr, rd_addr, wr_addr;
   logic we0, we1;
   logic signed [DW-1:0] wr_data, rd0, rd1, rd_data;
   jse_pkg::sweep_ctl_type sweep_ctl;

   // Clamp side to the supported range
   always_comb begin
      if (32'(side_ff) < 32'd2) begin
         side = jse_pkg::SIDE_W'(2);
      end else if (32'(side_ff) > 32'(jse_pkg::GRID_SIDE)) begin
         side = jse_pkg::SIDE_W'(jse_pkg::GRID_SIDE);
      end else begin
         side = jse_pkg::SIDE_W'(side_ff);
      end
   end

   assign ss         = jse_pkg::SS_W'(side) * jse_pkg::SS_W'(side);
   assign cells      = jse_pkg::CNT_W'(ss) * jse_pkg::CNT_W'(side);
   assign nbr_weight = jse_pkg::sat_add(jse_pkg::sat_add(wa_ff, wb_ff), wc_ff);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= 32'sd65536;
         wa_ff     <= 32'sd65536;
         wb_ff     <= 32'sd65536;
         wc_ff     <= 32'sd65536;
         steps_ff  <= 16'd1;
         side_ff   <= 5'd4;
      end else if (csr_write_en) begin
         unique case (csr_index)
            jse_pkg::REG_CENTER: center_ff <= csr_data;
            jse_pkg::REG_WA:     wa_ff     <= csr_data;
            jse_pkg::REG_WB:     wb_ff     <= csr_data;
            jse_pkg::REG_WC:     wc_ff     <= csr_data;
            jse_pkg::REG_STEPS:  steps_ff  <= csr_data[jse_pkg::STEP_W-1:0];
            jse_pkg::REG_SIDE:   side_ff   <= csr_data[jse_pkg::CFG_SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // Request decode
   assign req_ready = (state_ff == jse_pkg::TOP_IDLE) && !rd_pend_ff &&
                      (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign in_range  = 32'(req_payload.cell_index) < 32'(cells);
   assign req_addr  = AW'(req_payload.cell_index);
   assign run_req   = accept && (req_payload.command == jse_pkg::CMD_RUN);
   assign load_we   = accept && (req_payload.command == jse_pkg::CMD_LOAD) && in_range;
   assign read_req  = accept && (req_payload.command == jse_pkg::CMD_READ) && in_range;
   assign range_err = accept && !in_range &&
                      ((req_payload.command == jse_pkg::CMD_LOAD) ||
                       (req_payload.command == jse_pkg::CMD_READ));
   assign sw_start  = run_req && (steps_ff != '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jse_pkg::TOP_IDLE: begin
            if (run_req) state_in = (steps_ff == '0) ? jse_pkg::TOP_DONE : jse_pkg::TOP_RUN;
         end
         jse_pkg::TOP_RUN:  if (sweep_ctl.done) state_in = jse_pkg::TOP_DONE;
         jse_pkg::TOP_DONE: if (!rsp_valid_ff || rsp_ready) state_in = jse_pkg::TOP_IDLE;
         default:           state_in = jse_pkg::TOP_IDLE;
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      done_emit = 1'b0;
      unique case (state_ff)
         jse_pkg::TOP_DONE: done_emit = !rsp_valid_ff || rsp_ready;
         default:           done_emit = 1'b0;
      endcase
   end

   // Grid banks: loads go to the current bank, sweeps write the other one
   assign rd_addr = (state_ff == jse_pkg::TOP_IDLE) ? req_addr : sweep_ctl.rd_addr;
   assign wr_addr = load_we ? req_addr : sweep_ctl.wr_addr;
   assign wr_data = load_we ? req_payload.cell_value : sweep_ctl.wr_data;
   assign we0     = (load_we && !cur_ff) || (sweep_ctl.wr_en && cur_ff);
   assign we1     = (load_we && cur_ff) || (sweep_ctl.wr_en && !cur_ff);
   assign rd_data = cur_ff ? rd1 : rd0;

   jse_ram #(.WIDTH(DW), .DEPTH(jse_pkg::CELL_COUNT)) u_bank0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   jse_ram #(.WIDTH(DW), .DEPTH(jse_pkg::CELL_COUNT)) u_bank1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   jse_sweep u_sweep (
      .clock         (clock),
      .reset         (reset),
      .start         (sw_start),
      .side          (side),
      .center_weight (center_ff),
      .nbr_weight    (nbr_weight),
      .steps         (steps_ff),
      .rd_data       (rd_data),
      .ctl           (sweep_ctl)
   );

   // Result register: drop when taken, fill from errors, reads and run end
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (range_err) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = jse_pkg::KIND_RANGE;
         rsp_in.read_value  = '0;
      end else if (rd_pend_ff) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = jse_pkg::KIND_READ;
         rsp_in.read_value  = rd_data;
      end else if (done_emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = jse_pkg::KIND_RUN_DONE;
         rsp_in.read_value  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jse_pkg::TOP_IDLE;
         cur_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_ff ^ sweep_ctl.flip;
         rd_pend_ff   <= read_req;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `JSE_CHECK(a_sweep_write_in_run, sweep_ctl.wr_en, state_ff == jse_pkg::TOP_RUN, "sweep write outside run")
   `JSE_CHECK(a_pend_slot_free, rd_pend_ff, !rsp_valid_ff, "read data with result slot busy")
   `JSE_CHECK(a_no_write_clash, load_we, !sweep_ctl.wr_en, "load and sweep write together")
   `JSE_CHECK_NEXT(a_flip_swaps_bank, sweep_ctl.flip, cur_ff != $past(cur_ff), "bank did not swap")

endmodule
